// ===== rtl/pss_pkg.sv =====
// Package for the process scheduler with counting semaphores.
// Holds command codes, status codes, register indexes and table sizes; no dependencies.
package pss_pkg;

   typedef enum logic [3:0] {
      CMD_CREATE    = 4'd0,
      CMD_TERMINATE = 4'd1,
      CMD_TICK      = 4'd2,
      CMD_SLEEP     = 4'd3,
      CMD_SEM_WAIT  = 4'd4,
      CMD_SEM_POST  = 4'd5,
      CMD_SEM_GET   = 4'd6,
      CMD_PRINT_IRQ = 4'd7,
      CMD_GET_PID   = 4'd8
   } cmd_type;

   // pids and semaphore ids are 4 bits on the ports, so both tables stay at 16
   localparam int NUM_PROCS = 16;
   localparam int NUM_SEMS  = 16;

   localparam logic [1:0] ST_NONE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_SLEEP = 2'd2;
   localparam logic [1:0] ST_WAIT  = 2'd3;

   localparam logic REG_TIME_SLICE = 1'b0;
   localparam logic REG_PRINT_SEM  = 1'b1;

   localparam logic [15:0] TIME_SLICE_RESET = 16'd10;
   localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

endpackage

// ===== rtl/process_scheduler_semaphores.sv =====
// Process scheduler with counting semaphores: run, sleep and free FIFOs,
// per-process timing, semaphore counts and wait FIFOs.
// Depends on pss_pkg.
//
// Usage: raise start with command, current_pid, new_pid and argument while
// busy is low; the beat is taken at that edge. One result beat follows on
// rsp_* with rsp_valid high for exactly one cycle; the receiver cannot stall.
// Sequence: most commands pass S_READ, S_EXEC and S_DONE after accept (read the
// per-process / per-semaphore memory, modify, write back); a post that wakes
// a waiter adds S_SLICE. A tick walks the sleep FIFO, one entry per S_SCAN_RD
// and S_SCAN_CMP pair (wake time memory read then compare), then S_SLICE; busy
// is low again in the result cycle, so one command is in flight at a time and
// the next one may be taken with the result beat.
// sem_get clears the wait FIFO of the allocated semaphore by resetting its
// head and count; the wait FIFO slots live in one memory of NUM_SEMS*16
// entries indexed by {semaphore, slot}.
// Reset: synchronous, active high. It empties every FIFO, clears the
// slice, total and semaphore counts (valid bits per entry), refills the
// semaphore pool with ids in order and sets time_slice to 10,
// print_sem_id to 0. No clearing pass is needed.
// Configuration: APB-style, time_slice at 0x0, print_sem_id at 0x4; write
// only while idle.
module process_scheduler_semaphores
   import pss_pkg::*;
#(
   parameter int TICKS_PER_SECOND = 100
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_command,
   input  logic signed [4:0]  req_current_pid,
   input  logic [3:0]         req_new_pid,
   input  logic [15:0]        req_argument,
   output logic               rsp_valid,
   output logic signed [4:0]  rsp_next_current,
   output logic [3:0]         rsp_reply_value,
   output logic               rsp_reply_valid,
   output logic               rsp_pool_empty,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int PW = (NUM_PROCS > 2) ? $clog2(NUM_PROCS) : 1;
   localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int QW = PW;    // run, sleep, free and wait FIFOs hold NUM_PROCS entries
   localparam int QD = NUM_PROCS;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_EXEC, S_SCAN_RD, S_SCAN_CMP, S_SLICE, S_DONE
   } state_type;

   // configuration
   logic [15:0] time_slice_ff;
   logic [3:0]  print_sem_ff;
   logic        cfg_wr;
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         time_slice_ff <= TIME_SLICE_RESET;
         print_sem_ff  <= 4'd0;
      end else if (cfg_wr && paddr[1:0] == 2'd0 && paddr[2] == REG_TIME_SLICE) begin
         time_slice_ff <= pwdata[15:0];
      end else if (cfg_wr && paddr[1:0] == 2'd0 && paddr[2] == REG_PRINT_SEM) begin
         print_sem_ff <= pwdata[3:0];
      end
   end
   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == REG_TIME_SLICE) prdata = {16'd0, time_slice_ff};
      else                            prdata = {28'd0, print_sem_ff};
   end

   // per-process memories (synchronous read)
   logic [1:0]  status_mem [NUM_PROCS];
   logic [15:0] slice_mem  [NUM_PROCS];
   logic [31:0] total_mem  [NUM_PROCS];
   logic [31:0] wake_mem   [NUM_PROCS];
   logic [NUM_PROCS-1:0] pvalid_ff;     // entry written since reset
   // per-semaphore
   logic [15:0] count_mem [NUM_SEMS];
   logic [NUM_SEMS-1:0] svalid_ff;
   logic [QW-1:0] whead_ff [NUM_SEMS];
   logic [QW:0]   wcnt_ff  [NUM_SEMS];
   logic [3:0]    wq_mem   [NUM_SEMS*QD];

   // FIFOs in flip-flop rings
   logic [3:0] runq_ff [QD];  logic [QW-1:0] run_head_ff;   logic [QW:0] run_cnt_ff;
   logic [3:0] slpq_ff [QD];  logic [QW-1:0] slp_head_ff;   logic [QW:0] slp_cnt_ff;
   logic [3:0] freeq_ff [QD]; logic [QW-1:0] free_head_ff;  logic [QW:0] free_cnt_ff;
   logic [SW-1:0] pool_ff [NUM_SEMS];
   logic [SW-1:0] pool_head_ff;
   logic [SW:0]   pool_cnt_ff;

   logic [31:0] systime_ff;

   // command registers
   state_type   state_ff;
   logic [3:0]  cmd_ff;
   logic        has_ff;
   logic [PW-1:0] cur_ff;
   logic [3:0]  npid_ff;
   logic [15:0] arg_ff;
   logic [SW-1:0] sid_ff;
   logic        sid_ok_ff;
   logic [4:0]  scan_n_ff;
   logic [PW-1:0] scan_p_ff;
   logic        scan_ok_ff;
   logic        slice_end_ff;

   // memory read ports
   logic [PW-1:0] prd_addr;
   logic [15:0] sl_rd_ff;
   logic [31:0] tt_rd_ff;
   logic [31:0] wk_rd_ff;
   logic [15:0] cnt_rd_ff;
   logic [3:0]  wq_rd_ff;
   logic [SW-1:0] srd_addr;
   logic [$clog2(NUM_SEMS*QD)-1:0] wq_rd_addr;
   logic        prd_v_ff, srd_v_ff;

   logic [3:0] slp_top;
   assign slp_top = slpq_ff[slp_head_ff];

   // during the scan the port reads the wake time of the head sleeper
   assign prd_addr = (state_ff == S_SCAN_RD) ? slp_top[PW-1:0] : cur_ff;
   assign srd_addr = sid_ff;
   assign wq_rd_addr = {srd_addr, whead_ff[srd_addr]};

   always_ff @(posedge clock) begin
      sl_rd_ff  <= slice_mem[prd_addr];
      tt_rd_ff  <= total_mem[prd_addr];
      wk_rd_ff  <= wake_mem[prd_addr];
      prd_v_ff  <= pvalid_ff[prd_addr];
      cnt_rd_ff <= count_mem[srd_addr];
      srd_v_ff  <= svalid_ff[srd_addr];
      wq_rd_ff  <= wq_mem[wq_rd_addr];
   end

   logic [15:0] slice_now, count_now;
   logic [31:0] total_now;
   assign slice_now = prd_v_ff ? sl_rd_ff : 16'd0;
   assign total_now = prd_v_ff ? tt_rd_ff : 32'd0;
   assign count_now = srd_v_ff ? cnt_rd_ff : 16'd0;

   // slice accounting for a tick, decided while the read data is fresh
   logic [15:0] slice_inc;
   logic        slice_end;
   assign slice_inc = slice_now + 16'd1;
   assign slice_end = has_ff && cur_ff != '0 && slice_inc == time_slice_ff;

   // decode of the incoming beat
   logic          in_has;
   logic [SW-1:0] in_sid;
   logic          in_sid_ok;
   logic [15:0]   sid_src;
   assign in_has = !req_current_pid[4] && ({27'd0, req_current_pid} < NUM_PROCS);
   assign sid_src = (req_command == CMD_PRINT_IRQ) ? {12'd0, print_sem_ff} : req_argument;
   assign in_sid = sid_src[SW-1:0];
   assign in_sid_ok = {16'd0, sid_src} < NUM_SEMS;

   logic [31:0] ticks_mul;
   assign ticks_mul = TICKS_PER_SECOND * {16'd0, arg_ff};

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid <= 1'b0;
         pvalid_ff <= '0;
         svalid_ff <= '0;
         run_head_ff <= '0;  run_cnt_ff <= '0;
         slp_head_ff <= '0;  slp_cnt_ff <= '0;
         free_head_ff <= '0; free_cnt_ff <= '0;
         systime_ff <= '0;
         pool_head_ff <= '0;
         pool_cnt_ff <= (SW+1)'(NUM_SEMS);
         for (int i = 0; i < NUM_SEMS; i++) begin
            pool_ff[i] <= SW'(i);
            whead_ff[i] <= '0;
            wcnt_ff[i] <= '0;
         end
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cmd_ff    <= req_command;
                  has_ff    <= in_has;
                  cur_ff    <= req_current_pid[PW-1:0];
                  npid_ff   <= req_new_pid;
                  arg_ff    <= req_argument;
                  sid_ff    <= in_sid;
                  sid_ok_ff <= in_sid_ok;
                  rsp_reply_value <= 4'd0;
                  rsp_reply_valid <= 1'b0;
                  rsp_pool_empty  <= 1'b0;
                  state_ff  <= S_READ;
               end
            end
            S_READ: state_ff <= S_EXEC;   // memories deliver in S_EXEC
            S_EXEC: begin
               state_ff <= S_DONE;
               case (cmd_ff)
                  CMD_CREATE: begin
                     if (npid_ff != 4'd0 && {28'd0, npid_ff} < NUM_PROCS) begin
                        if (run_cnt_ff < (QW+1)'(QD)) begin
                           runq_ff[run_head_ff + run_cnt_ff[QW-1:0]] <= npid_ff;
                           run_cnt_ff <= run_cnt_ff + 1'b1;
                        end
                        status_mem[npid_ff[PW-1:0]] <= ST_RUN;
                        slice_mem[npid_ff[PW-1:0]]  <= 16'd0;
                        total_mem[npid_ff[PW-1:0]]  <= 32'd0;
                        pvalid_ff[npid_ff[PW-1:0]]  <= 1'b1;
                     end
                  end
                  CMD_TERMINATE: begin
                     if (has_ff && cur_ff != '0) begin
                        if (!prd_v_ff) begin
                           slice_mem[cur_ff] <= 16'd0;
                           total_mem[cur_ff] <= 32'd0;
                        end
                        status_mem[cur_ff] <= ST_NONE;
                        pvalid_ff[cur_ff]  <= 1'b1;
                        if (free_cnt_ff < (QW+1)'(QD)) begin
                           freeq_ff[free_head_ff + free_cnt_ff[QW-1:0]] <= 4'(cur_ff);
                           free_cnt_ff <= free_cnt_ff + 1'b1;
                        end
                        has_ff <= 1'b0;
                     end
                  end
                  CMD_TICK: begin
                     if (has_ff) begin
                        if (slice_end) status_mem[cur_ff] <= ST_RUN;
                        else if (!prd_v_ff) status_mem[cur_ff] <= ST_NONE;
                        slice_mem[cur_ff] <= slice_end ? 16'd0 : slice_inc;
                        total_mem[cur_ff] <= slice_end ? total_now + {16'd0, time_slice_ff}
                                             : total_now;
                        pvalid_ff[cur_ff] <= 1'b1;
                     end
                     // requeue of the expired process waits until after the sleepers
                     slice_end_ff <= slice_end;
                     systime_ff <= systime_ff + 32'd1;
                     scan_n_ff <= slp_cnt_ff;
                     state_ff <= S_SCAN_RD;
                  end
                  CMD_SLEEP: begin
                     if (has_ff) begin
                        if (!prd_v_ff) begin
                           slice_mem[cur_ff] <= 16'd0;
                           total_mem[cur_ff] <= 32'd0;
                        end
                        pvalid_ff[cur_ff] <= 1'b1;
                        wake_mem[cur_ff] <= systime_ff + ticks_mul;
                        status_mem[cur_ff] <= ST_SLEEP;
                        if (slp_cnt_ff < (QW+1)'(QD)) begin
                           slpq_ff[slp_head_ff + slp_cnt_ff[QW-1:0]] <= 4'(cur_ff);
                           slp_cnt_ff <= slp_cnt_ff + 1'b1;
                        end
                        has_ff <= 1'b0;
                     end
                  end
                  CMD_SEM_WAIT: begin
                     if (has_ff && sid_ok_ff) begin
                        if (count_now != 16'd0) begin
                           count_mem[sid_ff] <= count_now - 16'd1;
                           svalid_ff[sid_ff] <= 1'b1;
                        end else begin
                           if (wcnt_ff[sid_ff] < (QW+1)'(QD)) begin
                              wq_mem[{sid_ff, whead_ff[sid_ff] + wcnt_ff[sid_ff][QW-1:0]}]
                                 <= 4'(cur_ff);
                              wcnt_ff[sid_ff] <= wcnt_ff[sid_ff] + 1'b1;
                           end
                           if (!prd_v_ff) begin
                              slice_mem[cur_ff] <= 16'd0;
                              total_mem[cur_ff] <= 32'd0;
                           end
                           pvalid_ff[cur_ff] <= 1'b1;
                           status_mem[cur_ff] <= ST_WAIT;
                           has_ff <= 1'b0;
                        end
                     end
                  end
                  CMD_SEM_POST, CMD_PRINT_IRQ: begin
                     if (sid_ok_ff) begin
                        if (wcnt_ff[sid_ff] == '0) begin
                           if (count_now != COUNT_MAX) begin
                              count_mem[sid_ff] <= count_now + 16'd1;
                           end else begin
                              count_mem[sid_ff] <= count_now;
                           end
                           svalid_ff[sid_ff] <= 1'b1;
                        end else begin
                           // popped pid arrives on wq_rd_ff in the next state
                           whead_ff[sid_ff] <= whead_ff[sid_ff] + 1'b1;
                           wcnt_ff[sid_ff]  <= wcnt_ff[sid_ff] - 1'b1;
                           state_ff <= S_SLICE;
                        end
                     end
                  end
                  CMD_SEM_GET: begin
                     if (pool_cnt_ff == '0) begin
                        rsp_pool_empty <= 1'b1;
                     end else begin
                        pool_head_ff <= (pool_head_ff == SW'(NUM_SEMS-1)) ? '0
                                        : pool_head_ff + 1'b1;
                        pool_cnt_ff <= pool_cnt_ff - 1'b1;
                        whead_ff[pool_ff[pool_head_ff]] <= '0;
                        wcnt_ff[pool_ff[pool_head_ff]]  <= '0;
                        count_mem[pool_ff[pool_head_ff]] <= arg_ff;
                        svalid_ff[pool_ff[pool_head_ff]] <= 1'b1;
                        rsp_reply_value <= 4'(pool_ff[pool_head_ff]);
                        rsp_reply_valid <= 1'b1;
                     end
                  end
                  CMD_GET_PID: begin
                     if (has_ff) begin
                        rsp_reply_value <= 4'(cur_ff);
                        rsp_reply_valid <= 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            S_SCAN_RD: begin
               // pop head sleeper; its wake time is read this cycle
               if (scan_n_ff == 5'd0) begin
                  state_ff <= S_SLICE;
               end else begin
                  scan_p_ff   <= slp_top[PW-1:0];
                  scan_ok_ff  <= {28'd0, slp_top} < NUM_PROCS;
                  slp_head_ff <= slp_head_ff + 1'b1;
                  slp_cnt_ff  <= slp_cnt_ff - 1'b1;
                  scan_n_ff   <= scan_n_ff - 5'd1;
                  state_ff    <= S_SCAN_CMP;
               end
            end
            S_SCAN_CMP: begin
               if (scan_ok_ff && wk_rd_ff == systime_ff) begin
                  if (run_cnt_ff < (QW+1)'(QD)) begin
                     runq_ff[run_head_ff + run_cnt_ff[QW-1:0]] <= 4'(scan_p_ff);
                     run_cnt_ff <= run_cnt_ff + 1'b1;
                  end
                  status_mem[scan_p_ff] <= ST_RUN;
                  if (!pvalid_ff[scan_p_ff]) begin
                     slice_mem[scan_p_ff] <= 16'd0;
                     total_mem[scan_p_ff] <= 32'd0;
                  end
                  pvalid_ff[scan_p_ff] <= 1'b1;
               end else begin
                  // requeue: count just dropped, so there is room
                  slpq_ff[slp_head_ff + slp_cnt_ff[QW-1:0]] <= 4'(scan_p_ff);
                  slp_cnt_ff <= slp_cnt_ff + 1'b1;
               end
               state_ff <= S_SCAN_RD;
            end
            S_SLICE: begin
               state_ff <= S_DONE;
               if (cmd_ff == CMD_TICK) begin
                  if (slice_end_ff) begin
                     if (run_cnt_ff < (QW+1)'(QD)) begin
                        runq_ff[run_head_ff + run_cnt_ff[QW-1:0]] <= 4'(cur_ff);
                        run_cnt_ff <= run_cnt_ff + 1'b1;
                     end
                     has_ff <= 1'b0;
                  end
               end else begin
                  // wake the popped waiter
                  if ({28'd0, wq_rd_ff} < NUM_PROCS) begin
                     status_mem[wq_rd_ff[PW-1:0]] <= ST_RUN;
                     if (!pvalid_ff[wq_rd_ff[PW-1:0]]) begin
                        slice_mem[wq_rd_ff[PW-1:0]] <= 16'd0;
                        total_mem[wq_rd_ff[PW-1:0]] <= 32'd0;
                     end
                     pvalid_ff[wq_rd_ff[PW-1:0]] <= 1'b1;
                  end
                  if (run_cnt_ff < (QW+1)'(QD)) begin
                     runq_ff[run_head_ff + run_cnt_ff[QW-1:0]] <= wq_rd_ff;
                     run_cnt_ff <= run_cnt_ff + 1'b1;
                  end
               end
            end
            S_DONE: begin
               rsp_valid <= 1'b1;
               rsp_next_current <= has_ff ? {1'b0, 4'(cur_ff)} : 5'sh1F;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat longer than one cycle");
   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_cnt_ff <= (QW+1)'(QD))
      else $error("run FIFO over capacity");
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      pool_cnt_ff <= (SW+1)'(NUM_SEMS))
      else $error("semaphore pool over capacity");

endmodule

// ===== tb/process_scheduler_semaphores_tb.sv =====
// Testbench for process_scheduler_semaphores: directed and random kernel events,
// checked against an in-bench scheduler model kept in a scoreboard class.
// Depends on pss_pkg and the process_scheduler_semaphores RTL.
`timescale 1ns / 100ps

module process_scheduler_semaphores_tb
   import pss_pkg::*;
();

   localparam int NPROC = 16;
   localparam int NSEM = 16;
   localparam int FIFO_DEPTH = 16;
   localparam int TICKS_PER_SEC = 100;
   localparam logic [3:0] CMD_RESERVED_FIRST = 4'd9;
   localparam logic [3:0] CMD_RESERVED_LAST = 4'd15;
   localparam logic signed [4:0] PID_NONE = -5'sd1;
   localparam logic [2:0] ADDR_TIME_SLICE = {REG_TIME_SLICE, 2'b00};
   localparam logic [2:0] ADDR_PRINT_SEM = {REG_PRINT_SEM, 2'b00};
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic signed [4:0] next_current;
      logic [3:0]        reply_value;
      logic              reply_valid;
      logic              pool_empty;
   } event_reply_type;

   class sched_scoreboard;
      logic [15:0] time_slice;
      logic [3:0]  print_sem;
      logic [31:0] now_tick;
      logic [3:0]  run_q[$];
      logic [3:0]  sleep_q[$];
      logic [3:0]  free_q[$];
      logic [1:0]  status[NPROC];
      logic [15:0] slice_cnt[NPROC];
      logic [31:0] total_cnt[NPROC];
      logic [31:0] wake_tick[NPROC];
      logic [15:0] sem_cnt[NSEM];
      logic [3:0]  sem_waiters[NSEM][$];
      logic [3:0]  sem_pool[$];
      event_reply_type pending_replies[$];
      int errors;
      int replies_seen;
      int wakeups;

      function new();
         time_slice = TIME_SLICE_RESET;
         print_sem = 4'd0;
         now_tick = 32'd0;
         for (int i = 0; i < NPROC; i++) begin
            status[i] = ST_NONE;
            slice_cnt[i] = 16'd0;
            total_cnt[i] = 32'd0;
            wake_tick[i] = 32'd0;
         end
         for (int i = 0; i < NSEM; i++) begin
            sem_cnt[i] = 16'd0;
            sem_pool.push_back(4'(i));
         end
         errors = 0;
         replies_seen = 0;
         wakeups = 0;
      endfunction

      function void push_run(logic [3:0] p);
         if (run_q.size() < FIFO_DEPTH) run_q.push_back(p);
      endfunction

      function void post_sem(logic [15:0] id);
         logic [3:0] p;
         if (id >= NSEM) return;
         if (sem_waiters[id].size() == 0) begin
            if (sem_cnt[id] != COUNT_MAX) sem_cnt[id]++;
         end else begin
            p = sem_waiters[id].pop_front();
            status[p] = ST_RUN;
            push_run(p);
         end
      endfunction

      function void note_event(logic [3:0] cmd, logic [4:0] raw, logic [3:0] npid,
                               logic [15:0] arg);
         bit has;
         logic [3:0] cur;
         logic [3:0] p;
         int n;
         event_reply_type r;
         has = !raw[4];
         cur = raw[3:0];
         r = '0;
         case (cmd)
            CMD_CREATE: begin
               if (npid != 0) begin
                  push_run(npid);
                  status[npid] = ST_RUN;
                  slice_cnt[npid] = 16'd0;
                  total_cnt[npid] = 32'd0;
               end
            end
            CMD_TERMINATE: begin
               if (has && cur != 0) begin
                  status[cur] = ST_NONE;
                  if (free_q.size() < FIFO_DEPTH) free_q.push_back(cur);
                  has = 0;
               end
            end
            CMD_TICK: begin
               if (has) slice_cnt[cur]++;
               now_tick++;
               n = sleep_q.size();
               for (int i = 0; i < n; i++) begin
                  p = sleep_q.pop_front();
                  if (wake_tick[p] == now_tick) begin
                     push_run(p);
                     status[p] = ST_RUN;
                     wakeups++;
                  end else begin
                     sleep_q.push_back(p);
                  end
               end
               if (has && cur != 0 && slice_cnt[cur] == time_slice) begin
                  total_cnt[cur] += time_slice;
                  slice_cnt[cur] = 16'd0;
                  status[cur] = ST_RUN;
                  push_run(cur);
                  has = 0;
               end
            end
            CMD_SLEEP: begin
               if (has) begin
                  wake_tick[cur] = now_tick + TICKS_PER_SEC * 32'(arg);
                  if (sleep_q.size() < FIFO_DEPTH) sleep_q.push_back(cur);
                  status[cur] = ST_SLEEP;
                  has = 0;
               end
            end
            CMD_SEM_WAIT: begin
               if (has && arg < NSEM) begin
                  if (sem_cnt[arg] > 0) begin
                     sem_cnt[arg]--;
                  end else begin
                     if (sem_waiters[arg].size() < FIFO_DEPTH)
                        sem_waiters[arg].push_back(cur);
                     status[cur] = ST_WAIT;
                     has = 0;
                  end
               end
            end
            CMD_SEM_POST: post_sem(arg);
            CMD_SEM_GET: begin
               if (sem_pool.size() == 0) begin
                  r.pool_empty = 1'b1;
               end else begin
                  p = sem_pool.pop_front();
                  sem_waiters[p].delete();
                  sem_cnt[p] = arg;
                  r.reply_value = p;
                  r.reply_valid = 1'b1;
               end
            end
            CMD_PRINT_IRQ: post_sem({12'd0, print_sem});
            CMD_GET_PID: begin
               if (has) begin
                  r.reply_value = cur;
                  r.reply_valid = 1'b1;
               end
            end
            default: ;
         endcase
         r.next_current = has ? $signed({1'b0, cur}) : PID_NONE;
         pending_replies.push_back(r);
      endfunction

      function void check_reply(event_reply_type got);
         event_reply_type want;
         replies_seen++;
         if (pending_replies.size() == 0) begin
            $error("result beat with no expectation pending");
            errors++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.next_current !== want.next_current) begin
            $error("next_current: expected %0d, got %0d", want.next_current, got.next_current);
            errors++;
         end
         if (got.reply_value !== want.reply_value) begin
            $error("reply_value: expected %0d, got %0d", want.reply_value, got.reply_value);
            errors++;
         end
         if (got.reply_valid !== want.reply_valid) begin
            $error("reply_valid: expected %0b, got %0b", want.reply_valid, got.reply_valid);
            errors++;
         end
         if (got.pool_empty !== want.pool_empty) begin
            $error("pool_empty: expected %0b, got %0b", want.pool_empty, got.pool_empty);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [3:0]         req_command;
   logic signed [4:0]  req_current_pid;
   logic [3:0]         req_new_pid;
   logic [15:0]        req_argument;
   logic               rsp_valid;
   logic signed [4:0]  rsp_next_current;
   logic [3:0]         rsp_reply_value;
   logic               rsp_reply_valid;
   logic               rsp_pool_empty;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   sched_scoreboard sched = new();
   int idle_pct;
   int items_sent;
   int tick_count;
   logic signed [4:0] last_current;

   process_scheduler_semaphores dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_current_pid(req_current_pid),
      .req_new_pid(req_new_pid), .req_argument(req_argument),
      .rsp_valid(rsp_valid), .rsp_next_current(rsp_next_current),
      .rsp_reply_value(rsp_reply_value), .rsp_reply_valid(rsp_reply_valid),
      .rsp_pool_empty(rsp_pool_empty),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sched.check_reply({rsp_next_current, rsp_reply_value, rsp_reply_valid,
                            rsp_pool_empty});
         last_current <= rsp_next_current;
      end
   end

   task automatic send_event(logic [3:0] cmd, logic [4:0] raw, logic [3:0] npid,
                             logic [15:0] arg);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_current_pid <= raw;
      req_new_pid <= npid;
      req_argument <= arg;
      @(posedge clock);
      while (busy) @(posedge clock);
      sched.note_event(cmd, raw, npid, arg);
      items_sent++;
      if (cmd == CMD_TICK) tick_count++;
   endtask

   // hold start low, drain the block, then let any trailing work settle
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (sched.pending_replies.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (addr == ADDR_TIME_SLICE) sched.time_slice = data[15:0];
      else sched.print_sem = data[3:0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic random_event();
      int sel;
      int pick;
      logic [3:0] cmd;
      logic [4:0] raw;
      logic [15:0] arg;
      sel = $urandom_range(99);
      if (sel < 30) cmd = CMD_TICK;
      else if (sel < 40) cmd = CMD_CREATE;
      else if (sel < 46) cmd = CMD_TERMINATE;
      else if (sel < 54) cmd = CMD_SLEEP;
      else if (sel < 64) cmd = CMD_SEM_WAIT;
      else if (sel < 76) cmd = CMD_SEM_POST;
      else if (sel < 80) cmd = CMD_SEM_GET;
      else if (sel < 86) cmd = CMD_PRINT_IRQ;
      else if (sel < 97) cmd = CMD_GET_PID;
      else cmd = 4'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
      pick = $urandom_range(99);
      if (pick < 55) raw = 5'($urandom_range(NPROC - 1));
      else if (pick < 75) raw = last_current;
      else if (pick < 90) raw = PID_NONE;
      else raw = 5'($urandom);
      pick = $urandom_range(99);
      if (cmd == CMD_SLEEP) arg = (pick < 90) ? 16'($urandom_range(2)) : 16'($urandom);
      else if (cmd == CMD_SEM_GET) arg = (pick < 70) ? 16'($urandom_range(3)) : 16'($urandom);
      else arg = (pick < 85) ? 16'($urandom_range(NSEM - 1)) : 16'($urandom);
      send_event(cmd, raw, 4'($urandom), arg);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_GET_PID;
      req_current_pid = PID_NONE;
      req_new_pid = 4'd0;
      req_argument = 16'd0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = 3'd0;
      pwdata = 32'd0;
      idle_pct = 0;
      items_sent = 0;
      tick_count = 0;
      last_current = PID_NONE;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, each command and the corner cases
      send_event(CMD_CREATE, PID_NONE, 4'd0, 16'd0);
      send_event(CMD_CREATE, PID_NONE, 4'd15, 16'hFFFF);
      send_event(CMD_CREATE, 5'd0, 4'd3, 16'd0);
      send_event(CMD_GET_PID, PID_NONE, 4'd0, 16'd0);
      send_event(CMD_GET_PID, 5'd15, 4'd0, 16'd0);
      send_event(CMD_GET_PID, 5'b10000, 4'd0, 16'd0);
      send_event(CMD_SEM_GET, PID_NONE, 4'd0, 16'hFFFF);
      send_event(CMD_SEM_POST, 5'd3, 4'd0, 16'd0);
      send_event(CMD_PRINT_IRQ, 5'd3, 4'd0, 16'd0);
      send_event(CMD_SEM_WAIT, 5'd3, 4'd0, 16'd0);
      send_event(CMD_SEM_WAIT, 5'd3, 4'd0, 16'd16);
      send_event(CMD_SEM_POST, 5'd3, 4'd0, 16'hFFFF);
      send_event(CMD_SEM_GET, 5'd3, 4'd0, 16'd0);
      send_event(CMD_SEM_WAIT, 5'd5, 4'd0, 16'd1);
      send_event(CMD_SEM_POST, 5'd0, 4'd0, 16'd1);
      send_event(CMD_SLEEP, PID_NONE, 4'd0, 16'd1);
      send_event(CMD_SLEEP, 5'd3, 4'd0, 16'd1);
      send_event(CMD_SEM_WAIT, PID_NONE, 4'd0, 16'd0);
      send_event(CMD_TICK, 5'd15, 4'd0, 16'd0);
      send_event(CMD_TICK, PID_NONE, 4'd0, 16'd0);
      send_event(CMD_TERMINATE, 5'd0, 4'd0, 16'd0);
      send_event(CMD_TERMINATE, PID_NONE, 4'd0, 16'd0);
      send_event(CMD_TERMINATE, 5'd15, 4'd0, 16'd0);
      send_event(CMD_RESERVED_FIRST, 5'd1, 4'd1, 16'd1);
      send_event(CMD_RESERVED_LAST, 5'd1, 4'd1, 16'd1);

      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               csr_write(ADDR_TIME_SLICE, 32'd1);
               csr_write(ADDR_PRINT_SEM, 32'd15);
               idle_pct = 0;
            end
            1: begin
               csr_write(ADDR_TIME_SLICE, 32'd3);
               csr_write(ADDR_PRINT_SEM, 32'd1);
               idle_pct = 60;
            end
            2: begin
               csr_write(ADDR_TIME_SLICE, 32'd65535);
               csr_write(ADDR_PRINT_SEM, 32'd0);
               idle_pct = 0;
            end
            default: begin
               csr_write(ADDR_TIME_SLICE, 32'd5);
               csr_write(ADDR_PRINT_SEM, 32'd2);
               idle_pct = 11;
            end
         endcase
         for (int i = 0; i < 225; i++) random_event();
      end

      wait_idle();
      $display("Ran %0d events (%0d ticks, %0d sleepers woken), checked %0d result beats",
               items_sent, tick_count, sched.wakeups, sched.replies_seen);
      $display("over four slice and print-semaphore settings with and without sender gaps");
      if (sched.errors == 0 && sched.pending_replies.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
